[rtl/pdd_pkg.sv]
// Shared constants, types and helper functions of the point direction block.
package pdd_pkg;

    // Angle accumulator scale: degrees with 24 fraction bits.
    localparam int TBL_FRAC = 24;
    localparam int TBL_LEN  = 24;
    // Signed accumulator width; it covers well over one full turn at this scale.
    localparam int Z_W      = 35;
    localparam int OUT_W    = 16;

    // atan(2^-i) in degrees, scaled by 2^24 and rounded to nearest.
    localparam logic [29:0] ATAN_DEG_TBL [0:TBL_LEN-1] = '{
        30'd754974720, 30'd445687602, 30'd235489088, 30'd119537938,
        30'd60000934,  30'd30029717,  30'd15018523,  30'd7509720,
        30'd3754917,   30'd1877466,   30'd938734,    30'd469367,
        30'd234684,    30'd117342,    30'd58671,     30'd29335,
        30'd14668,     30'd7334,      30'd3667,      30'd1833,
        30'd917,       30'd458,       30'd229,       30'd115
    };

    // Items whose heading is fixed by an axis-aligned vector bypass the rotator.
    typedef struct packed {
        logic               special;
        logic [OUT_W-1:0]   spec_deg;
    } pdd_ctl_t;

    // Whole degrees at the output fraction width, kept to the output field width.
    function automatic logic [OUT_W-1:0] deg_code(input int deg, input int frac);
        logic [31:0] scaled;
        scaled = 32'(deg) << frac;
        return scaled[OUT_W-1:0];
    endfunction

endpackage

[rtl/point_direction_degrees.sv]
// Top level of the point direction block: heading of a target seen from a start point.
// Registers on the path: the front stage, one per rotation cell, and the output stage.
// Throughput: one coordinate pair per cycle; every stage of the rotation chain is
// registered and carries its own valid flag, so bubbles close up under back-pressure.
// Reset (aresetn low at a rising edge) empties every stage; pairs still in flight are
// dropped, and no result is offered until a new pair has passed through the chain.
module point_direction_degrees import pdd_pkg::*; #(
    parameter int COORD_WIDTH     = 16,
    parameter int STAGES          = 16,
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // s_tdata fields from bit 0 up: start_x, start_y, target_x, target_y,
    // each COORD_WIDTH bits, two's complement; zero fill to a whole byte.
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // m_tdata fields from bit 0 up: heading_deg, 16 bits, unsigned degrees with
    // ANGLE_FRAC_BITS fraction bits.
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int TDATA_W  = ((4*COORD_WIDTH+7)/8)*8;
    // Rotated vectors grow by the CORDIC gain of about 1.65 on top of the
    // one-bit-wider difference, so two guard bits are kept above it.
    localparam int XW       = COORD_WIDTH + 3;
    localparam int FULL_DEG = 360 << ANGLE_FRAC_BITS;

    // Chain links: entry 0 is the front stage output, entry STAGES the last cell.
    logic                  valid_w [0:STAGES];
    logic                  ready_w [0:STAGES];
    logic signed [XW-1:0]  x_w     [0:STAGES];
    logic signed [XW-1:0]  y_w     [0:STAGES];
    logic signed [Z_W-1:0] z_w     [0:STAGES];
    pdd_ctl_t              ctl_w   [0:STAGES];

    pdd_front #(
        .COORD_WIDTH     (COORD_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
        .TDATA_W         (TDATA_W),
        .XW              (XW)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .valid_i (s_tvalid),
        .ready_o (s_tready),
        .data_i  (s_tdata),
        .valid_o (valid_w[0]),
        .ready_i (ready_w[0]),
        .x_o     (x_w[0]),
        .y_o     (y_w[0]),
        .z_o     (z_w[0]),
        .ctl_o   (ctl_w[0])
    );

    // One cell per rotation step; cell g shifts by g and uses atan(2^-g).
    for (genvar g = 0; g < STAGES; g++) begin : g_cell
        pdd_cell #(
            .STAGE (g),
            .XW    (XW)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .valid_i (valid_w[g]),
            .ready_o (ready_w[g]),
            .x_i     (x_w[g]),
            .y_i     (y_w[g]),
            .z_i     (z_w[g]),
            .ctl_i   (ctl_w[g]),
            .valid_o (valid_w[g+1]),
            .ready_i (ready_w[g+1]),
            .x_o     (x_w[g+1]),
            .y_o     (y_w[g+1]),
            .z_o     (z_w[g+1]),
            .ctl_o   (ctl_w[g+1])
        );
    end

    // The final x and y are not needed: the angle alone forms the result.
    pdd_back #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .valid_i  (valid_w[STAGES]),
        .ready_o  (ready_w[STAGES]),
        .z_i      (z_w[STAGES]),
        .ctl_i    (ctl_w[STAGES]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // The input can only be refused once every stage, the output included, is full.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input refused while the chain still has room");

    // Reset leaves nothing on offer at the output.
    assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result offered straight after reset");

    // Where a full turn fits the output field, the heading stays below it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (FULL_DEG <= 65535)) |-> (32'(m_tdata) < FULL_DEG))
        else $error("heading not wrapped below a full turn");

endmodule

[rtl/pdd_front.sv]
// Input stage: difference vector, axis special cases and half-turn pre-rotation.
module pdd_front import pdd_pkg::*; #(
    parameter int COORD_WIDTH     = 16,
    parameter int ANGLE_FRAC_BITS = 7,
    parameter int TDATA_W         = 64,
    parameter int XW              = 19
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 valid_i,
    output logic                 ready_o,
    input  logic [TDATA_W-1:0]   data_i,
    output logic                 valid_o,
    input  logic                 ready_i,
    output logic signed [XW-1:0] x_o,
    output logic signed [XW-1:0] y_o,
    output logic signed [Z_W-1:0] z_o,
    output pdd_ctl_t             ctl_o
);

    localparam int CW = COORD_WIDTH;
    localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(180) << TBL_FRAC;

    logic signed [CW-1:0]  sx, sy, tx, ty;
    logic signed [CW:0]    dx, dy;
    logic signed [XW-1:0]  x_next, y_next;
    logic signed [Z_W-1:0] z_next;
    pdd_ctl_t              ctl_next;

    logic                  valid_reg;
    logic signed [XW-1:0]  x_reg, y_reg;
    logic signed [Z_W-1:0] z_reg;
    pdd_ctl_t              ctl_reg;

    always_comb begin
        sx = data_i[CW-1:0];
        sy = data_i[2*CW-1:CW];
        tx = data_i[3*CW-1:2*CW];
        ty = data_i[4*CW-1:3*CW];
        dx = (CW+1)'(tx) - (CW+1)'(sx);
        dy = (CW+1)'(ty) - (CW+1)'(sy);

        ctl_next.special  = 1'b0;
        ctl_next.spec_deg = '0;
        if (dy == '0) begin
            ctl_next.special  = 1'b1;
            ctl_next.spec_deg = dx[CW] ? deg_code(180, ANGLE_FRAC_BITS) : '0;
        end else if (dx == '0) begin
            ctl_next.special  = 1'b1;
            ctl_next.spec_deg = dy[CW] ? deg_code(270, ANGLE_FRAC_BITS)
                                       : deg_code(90, ANGLE_FRAC_BITS);
        end

        // Vectors in the left half-plane are turned by 180 degrees first.
        if (dx[CW]) begin
            x_next = -XW'(dx);
            y_next = -XW'(dy);
            z_next = HALF_TURN;
        end else begin
            x_next = XW'(dx);
            y_next = XW'(dy);
            z_next = '0;
        end
    end

    assign ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            ctl_reg <= ctl_next;
        end
    end

    assign valid_o = valid_reg;
    assign x_o     = x_reg;
    assign y_o     = y_reg;
    assign z_o     = z_reg;
    assign ctl_o   = ctl_reg;

endmodule

[rtl/pdd_cell.sv]
// One vectoring rotation cell of the shift-add chain.
module pdd_cell import pdd_pkg::*; #(
    parameter int STAGE = 0,
    parameter int XW    = 19
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  valid_i,
    output logic                  ready_o,
    input  logic signed [XW-1:0]  x_i,
    input  logic signed [XW-1:0]  y_i,
    input  logic signed [Z_W-1:0] z_i,
    input  pdd_ctl_t              ctl_i,
    output logic                  valid_o,
    input  logic                  ready_i,
    output logic signed [XW-1:0]  x_o,
    output logic signed [XW-1:0]  y_o,
    output logic signed [Z_W-1:0] z_o,
    output pdd_ctl_t              ctl_o
);

    localparam logic signed [Z_W-1:0] STEP = Z_W'(ATAN_DEG_TBL[STAGE]);

    logic signed [XW-1:0]  xs, ys, x_next, y_next;
    logic signed [Z_W-1:0] z_next;

    logic                  valid_reg;
    logic signed [XW-1:0]  x_reg, y_reg;
    logic signed [Z_W-1:0] z_reg;
    pdd_ctl_t              ctl_reg;

    always_comb begin
        xs = x_i >>> STAGE;
        ys = y_i >>> STAGE;
        // Rotate towards the x axis; the sign of y picks the direction.
        if (!y_i[XW-1]) begin
            x_next = x_i + ys;
            y_next = y_i - xs;
            z_next = z_i + STEP;
        end else begin
            x_next = x_i - ys;
            y_next = y_i + xs;
            z_next = z_i - STEP;
        end
    end

    assign ready_o = !valid_reg || ready_i;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_o) begin
            valid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            ctl_reg <= ctl_i;
        end
    end

    assign valid_o = valid_reg;
    assign x_o     = x_reg;
    assign y_o     = y_reg;
    assign z_o     = z_reg;
    assign ctl_o   = ctl_reg;

    // After pre-rotation x only ever grows, so it never turns negative.
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !x_reg[XW-1])
        else $error("rotation cell holds a negative x");

endmodule

[rtl/pdd_back.sv]
// Output stage: wrap into one turn, round to the output format, hold the result.
module pdd_back import pdd_pkg::*; #(
    parameter int ANGLE_FRAC_BITS = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  valid_i,
    output logic                  ready_o,
    input  logic signed [Z_W-1:0] z_i,
    input  pdd_ctl_t              ctl_i,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_W-1:0]      m_tdata
);

    localparam int SH = TBL_FRAC - ANGLE_FRAC_BITS;
    localparam logic signed [Z_W-1:0] RND      = Z_W'(1) << (SH - 1);
    localparam logic signed [Z_W-1:0] WRAP_RND = (Z_W'(360) << TBL_FRAC) + RND;
    localparam logic [Z_W-1:0]        FULL     = Z_W'(360) << ANGLE_FRAC_BITS;

    logic signed [Z_W-1:0] z_adj;
    logic [Z_W-1:0]        acc, acc_wrap;
    logic [OUT_W-1:0]      m_tdata_next;
    logic                  m_tvalid_reg;
    logic [OUT_W-1:0]      m_tdata_reg;

    always_comb begin
        // Negative angles gain a full turn in the same add as the rounding.
        z_adj    = z_i + (z_i[Z_W-1] ? WRAP_RND : RND);
        acc      = Z_W'(z_adj >>> SH);
        acc_wrap = (acc >= FULL) ? acc - FULL : acc;
        m_tdata_next = ctl_i.special ? ctl_i.spec_deg : acc_wrap[OUT_W-1:0];
    end

    assign ready_o = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ready_o) begin
            m_tvalid_reg <= valid_i;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready_o && valid_i) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
